@@ design/sla_pkg.sv @@
`default_nettype none

package sla_pkg;

  // line buffer geometry
  localparam int BUFFER_BYTES = 64;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);

  // counts of delivered characters, wide enough for the 6-bit limit
  localparam int CNT_W   = 7;
  localparam int LIMIT_W = 6;

  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_MAX_OUT_CHARS = 3'd0;
  localparam logic [LIMIT_W-1:0] MAX_OUT_RESET     = 6'd63;

  // control characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

endpackage

`default_nettype wire

@@ design/serial_line_assembler.sv @@
`default_nettype none

// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------
// input     | in        | in_valid / in_ready      | rx_byte
// output    | out       | out_valid / out_ready    | line_byte, last_of_line,
//           |           |                          | overflow_total
// config    | in        | psel/penable/pwrite      | paddr, pwdata, prdata (pready = 1)
//
// an ordinary byte, carriage return or overflowing byte is accepted without a stall
// a line feed that ends a line of n delivered characters holds the input
// until all n are delivered, output stalls included: each character is one
// read of the single line store port followed by an output transfer
// synchronous active-high reset clears the fill count, discard flag and drop
// counter and reloads the limit of 63; the line store itself is never cleared
// in_ready drops while a line is being delivered

module serial_line_assembler
  import sla_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BYTE_W-1:0]  rx_byte,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       line_byte,
  output logic                    last_of_line,
  output logic [TOTAL_W-1:0]      overflow_total,

  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_t;

  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_BYTES - 1);

  state_t               state, state_next;
  logic [ADDR_W-1:0]    fill_count;
  logic                 discarding;
  logic [TOTAL_W-1:0]   dropped_lines;
  logic [LIMIT_W-1:0]   max_out_chars;
  logic [CNT_W-1:0]     emit_count;
  logic [ADDR_W-1:0]    rd_idx;

  // line store, one synchronous write and one registered read port
  logic [BYTE_W-1:0]    line_store [BUFFER_BYTES];
  logic [BYTE_W-1:0]    rd_data;
  logic                 wr_en;
  logic                 rd_en;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 is_cr;
  logic                 is_lf;
  logic                 emit_last;
  logic [CNT_W-1:0]     fill_ext;
  logic [CNT_W-1:0]     limit;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register read-back; any address above the one register reads zero
  always_comb begin
    prdata = '0;
    if (paddr == REG_MAX_OUT_CHARS) begin
      prdata = PDATA_W'(max_out_chars);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (state == S_SEND);
  assign out_xfer  = out_valid && out_ready;

  assign is_cr = (rx_byte == CH_CR);
  assign is_lf = (rx_byte == CH_LF);

  // a zero limit behaves as one
  assign fill_ext = CNT_W'(fill_count);
  assign limit    = (max_out_chars == '0) ? CNT_W'(1) : CNT_W'(max_out_chars);

  // store an ordinary byte while there is room and no discard is pending
  assign wr_en = in_xfer && !is_cr && !is_lf && !discarding && (fill_count < FILL_MAX);
  assign rd_en = (state == S_READ);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[fill_count] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= line_store[rd_idx];
    end
  end

  assign emit_last      = (CNT_W'(rd_idx) + CNT_W'(1) == emit_count);
  assign line_byte      = rd_data;
  assign last_of_line   = emit_last;
  // no bytes are taken during delivery, so the counter holds still
  assign overflow_total = dropped_lines;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && !is_cr && !discarding && is_lf && (fill_count != '0)) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_xfer) begin
          state_next = emit_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      discarding    <= 1'b0;
      dropped_lines <= '0;
      max_out_chars <= MAX_OUT_RESET;
      rd_idx        <= '0;
      emit_count    <= '0;
    end else begin
      state <= state_next;

      if (cfg_write && (paddr == REG_MAX_OUT_CHARS)) begin
        max_out_chars <= pwdata[LIMIT_W-1:0];
      end

      if (in_xfer && !is_cr) begin
        if (discarding) begin
          // line feed closes the dropped line
          if (is_lf) begin
            discarding <= 1'b0;
            fill_count <= '0;
          end
        end else if (is_lf) begin
          if (fill_count != '0) begin
            emit_count <= (fill_ext < limit) ? fill_ext : limit;
            rd_idx     <= '0;
          end
          fill_count <= '0;
        end else if (fill_count < FILL_MAX) begin
          fill_count <= fill_count + ADDR_W'(1);
        end else begin
          // line outgrew the buffer: drop it and skip to the next line feed
          dropped_lines <= dropped_lines + TOTAL_W'(1);
          fill_count    <= '0;
          discarding    <= 1'b1;
        end
      end

      if (out_xfer && !emit_last) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
